// ===== sv/dsbt_pkg.sv =====
// Shared types, widths and state codes for the divisor sum and betrothed test block.
package dsbt_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int TRIAL_W    = DATA_WIDTH / 2 + 1;
	localparam int CNT_W      = $clog2(DATA_WIDTH + 1);

	typedef logic [DATA_WIDTH-1:0] word_t;
	typedef logic [TRIAL_W-1:0]    trial_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	typedef struct packed {
		logic   busy;
		logic   done;
		word_t  quotient;
		trial_t remainder;
	} div_sts_t;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_START  = 2'd1;
	localparam logic [1:0] ST_WAIT   = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

endpackage

// ===== sv/dsbt_divider.sv =====
// Restoring radix-2 divider that produces one quotient bit per cycle.
module dsbt_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  dsbt_pkg::word_t   dividend,
	input  dsbt_pkg::trial_t  divisor,
	output dsbt_pkg::div_sts_t sts
);
	import dsbt_pkg::*;

	logic             busy_q;
	logic             done_q;
	cnt_t             cnt_q;
	word_t            quo_q;
	trial_t           rem_q;
	trial_t           dvs_q;
	logic [TRIAL_W:0] rem_shift;
	logic [TRIAL_W:0] rem_diff;
	logic             rem_ge;

	assign rem_shift = {rem_q, quo_q[DATA_WIDTH-1]};
	assign rem_diff  = rem_shift - {1'b0, dvs_q};
	assign rem_ge    = rem_shift >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DATA_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DATA_WIDTH-2:0], rem_ge};
			rem_q <= rem_ge ? rem_diff[TRIAL_W-1:0] : rem_shift[TRIAL_W-1:0];
		end
	end

	assign sts.busy      = busy_q;
	assign sts.done      = done_q;
	assign sts.quotient  = quo_q;
	assign sts.remainder = rem_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("Divider did not go busy after a start.");

	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0)
		else $error("Divider busy with an empty bit count.");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < dvs_q)
		else $error("Divider remainder is not below the divisor.");

endmodule

// ===== sv/divisor_sum_betrothed_test.sv =====
// Top level: trial-division divisor sum with a betrothed-pair test on one shared divider.
//
//   Channel | Signals                          | Direction | Width
//   request | in_valid, in_ready, number       | in        | 32
//   result  | out_valid, out_ready,            | out       | 32 + 1
//           | divisor_sum, is_betrothed        |           |
//
// Each trial divisor i takes one run of the shared divider; one pass over a value v tries
// i from 2 upward until the quotient falls below i, and a second pass over the sum runs
// only when the sum exceeds the number. Values of 2 or less never start the divider.
// Reset is asynchronous and clears all control. The block accepts no new request while
// one is in work; a finished result waits in the output register, and a new request can
// be taken while it is still pending.
module divisor_sum_betrothed_test (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  dsbt_pkg::word_t number,
	output logic            out_valid,
	input  logic            out_ready,
	output dsbt_pkg::word_t divisor_sum,
	output logic            is_betrothed
);
	import dsbt_pkg::*;

	logic [1:0] state_q;
	logic       pass2_q;
	logic       out_valid_q;
	word_t      num_q;
	word_t      val_q;
	word_t      acc_q;
	word_t      sum_q;
	trial_t     trial_q;
	logic       flag_q;
	word_t      out_sum_q;
	logic       out_flag_q;

	logic       div_start;
	div_sts_t   div_sts;
	logic       pass_end;
	logic       trial_hit;
	word_t      trial_ext;
	word_t      acc_next;

	assign trial_ext = {{(DATA_WIDTH-TRIAL_W){1'b0}}, trial_q};
	assign div_start = (state_q == ST_START) && (val_q > word_t'(2));
	assign trial_hit = div_sts.remainder == '0;
	assign acc_next  = acc_q + div_sts.quotient
		+ ((div_sts.quotient != trial_ext) ? trial_ext : '0);

	always_comb begin
		unique case (state_q)
			ST_START: pass_end = val_q <= word_t'(2);
			ST_WAIT:  pass_end = div_sts.done && (div_sts.quotient < trial_ext);
			default:  pass_end = 1'b0;
		endcase
	end

	dsbt_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (val_q),
		.divisor  (trial_q),
		.sts      (div_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pass2_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						pass2_q <= 1'b0;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					if (pass_end) begin
						state_q <= (!pass2_q && acc_q > num_q) ? ST_START : ST_FINISH;
						pass2_q <= !pass2_q && acc_q > num_q;
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (pass_end) begin
						state_q <= (!pass2_q && acc_q > num_q) ? ST_START : ST_FINISH;
						pass2_q <= !pass2_q && acc_q > num_q;
					end else if (div_sts.done) begin
						state_q <= ST_START;
					end
				end
				ST_FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			num_q   <= number;
			val_q   <= number;
			acc_q   <= '0;
			trial_q <= TRIAL_W'(2);
		end else if (pass_end) begin
			if (!pass2_q) begin
				sum_q  <= acc_q;
				flag_q <= 1'b0;
				val_q  <= acc_q;
			end else begin
				flag_q <= acc_q == num_q;
			end
			acc_q   <= '0;
			trial_q <= TRIAL_W'(2);
		end else if (state_q == ST_WAIT && div_sts.done) begin
			if (trial_hit) begin
				acc_q <= acc_next;
			end
			trial_q <= trial_q + 1'b1;
		end
		if (state_q == ST_FINISH && (!out_valid_q || out_ready)) begin
			out_sum_q  <= sum_q;
			out_flag_q <= flag_q;
		end
	end

	assign in_ready     = state_q == ST_IDLE;
	assign out_valid    = out_valid_q;
	assign divisor_sum  = out_sum_q;
	assign is_betrothed = out_flag_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_START)
		else $error("An accepted request did not start a pass.");

	a_start_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_sts.busy)
		else $error("Divider started while still busy.");

	a_trial_floor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WAIT |-> trial_q >= TRIAL_W'(2))
		else $error("Trial divisor fell below two.");

	a_pass2_sum: assert property (@(posedge clk) disable iff (!arst_n)
		pass2_q && state_q != ST_IDLE && state_q != ST_FINISH |-> sum_q > num_q)
		else $error("Second pass runs on a sum that does not exceed the number.");

endmodule
